// ----- hdl/bidt_pkg.sv -----
package bidt_pkg;

    // Table geometry.
    localparam int MAX_IDS    = 256;
    localparam int ID_W       = 9;
    localparam int SLOT_W     = $clog2(MAX_IDS);
    localparam int SIZE_W     = 31;
    localparam int USAGE_W    = 16;
    localparam int DATA_W     = 32;

    // The bitmap is searched one group per cycle.
    localparam int GROUP_W    = 32;
    localparam int LANE_W     = $clog2(GROUP_W);
    localparam int NUM_GROUPS = MAX_IDS / GROUP_W;
    localparam int GRP_IDX_W  = SLOT_W - LANE_W;

    // Command codes.
    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_DELETE  = 3'd1;
    localparam logic [2:0] CMD_QUERY   = 3'd2;
    localparam logic [2:0] CMD_SETDATA = 3'd3;
    localparam logic [2:0] CMD_CHECK   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BADID = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Request to the size and usage store.
    typedef struct packed {
        logic                rd;
        logic                wr_size;
        logic                wr_usage;
        logic [SLOT_W-1:0]   addr;
        logic [SIZE_W-1:0]   size;
        logic [USAGE_W-1:0]  usage;
    } t_mem_req;

    // Outcome of a bitmap search.
    typedef struct packed {
        logic                done;
        logic                found;
        logic [SLOT_W-1:0]   slot;
    } t_scan_res;

endpackage

// ----- hdl/buffer_id_allocator_table_core.sv -----
// Object ID table with lowest-free allocation. A command word is taken when start is high
// and busy is low; exactly one result word follows, shown for a single cycle with o_done
// high, and it must be captured then because the block cannot be held off. Delete, query,
// set data, sub-range check and unknown commands go through a step to check the ID and read
// the single-port size/usage memory, a step to act on the read data, and the result step,
// in which the next start can already be taken. Allocate is paced by the bitmap search
// unit, which inspects one 32-slot group per cycle over the 8 groups of the 256-entry
// table. No clearing pass is needed after reset.
module buffer_id_allocator_table_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_command,
    input  logic [bidt_pkg::ID_W-1:0]          i_obj_id,
    input  logic signed [bidt_pkg::DATA_W-1:0] i_length,
    input  logic signed [bidt_pkg::DATA_W-1:0] i_start_offset,
    input  logic [bidt_pkg::USAGE_W-1:0]       i_usage_hint,
    output logic                               o_done,
    output logic [1:0]                         o_status,
    output logic [bidt_pkg::ID_W-1:0]          o_new_id,
    output logic                               o_entry_valid,
    output logic [bidt_pkg::SIZE_W-1:0]        o_entry_size,
    output logic [bidt_pkg::USAGE_W-1:0]       o_entry_usage
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0]                         r_state, n_state;
    logic [bidt_pkg::MAX_IDS-1:0]       r_alloc;
    logic [bidt_pkg::ID_W-1:0]          r_hw, n_hw;

    // Captured command word.
    logic [2:0]                         r_cmd;
    logic [bidt_pkg::ID_W-1:0]          r_id;
    logic [bidt_pkg::SLOT_W-1:0]        r_slot;
    logic signed [bidt_pkg::DATA_W-1:0] r_len;
    logic signed [bidt_pkg::DATA_W-1:0] r_off;
    logic [bidt_pkg::USAGE_W-1:0]       r_hint;
    logic                               r_live, n_live;

    // Result word.
    logic                               r_done, n_done;
    logic [1:0]                         r_status, n_status;
    logic [bidt_pkg::ID_W-1:0]          r_new_id, n_new_id;
    logic                               r_valid, n_valid;
    logic [bidt_pkg::SIZE_W-1:0]        r_size, n_size;
    logic [bidt_pkg::USAGE_W-1:0]       r_usage, n_usage;

    logic                               w_accept;
    logic [bidt_pkg::ID_W-1:0]          w_id_m1;
    logic                               w_bit_set;
    logic                               w_bit_clr;
    logic [bidt_pkg::SLOT_W-1:0]        w_bit_idx;
    logic [bidt_pkg::DATA_W-1:0]        w_end;
    logic                               w_range_err;
    logic [bidt_pkg::SIZE_W-1:0]        w_new_size;
    logic [bidt_pkg::GRP_IDX_W-1:0]     w_grp;
    logic [bidt_pkg::GROUP_W-1:0]       w_group;
    bidt_pkg::t_scan_res                w_scan;
    bidt_pkg::t_mem_req                 w_mem;
    logic [bidt_pkg::SIZE_W-1:0]        w_rd_size;
    logic [bidt_pkg::USAGE_W-1:0]       w_rd_usage;

    assign w_accept = start && !busy;
    assign w_id_m1  = i_obj_id - 1'b1;

    // Bitmap search unit, fed one group of allocation flags per cycle.
    assign w_group = r_alloc[w_grp * bidt_pkg::GROUP_W +: bidt_pkg::GROUP_W];

    bidt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_accept && (i_command == bidt_pkg::CMD_ALLOC)),
        .i_group (w_group),
        .o_grp   (w_grp),
        .o_res   (w_scan)
    );

    bidt_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_size  (w_rd_size),
        .o_usage (w_rd_usage)
    );

    // Sub-range test: both operands non-negative, so the end fits in 32 bits.
    assign w_end       = {1'b0, r_off[bidt_pkg::DATA_W-2:0]}
                       + {1'b0, r_len[bidt_pkg::DATA_W-2:0]};
    assign w_range_err = (w_rd_size == '0) || r_off[bidt_pkg::DATA_W-1]
                       || r_len[bidt_pkg::DATA_W-1] || (w_end > {1'b0, w_rd_size});

    // A non-positive length stores an empty size.
    assign w_new_size = (r_len <= 0) ? '0 : r_len[bidt_pkg::SIZE_W-1:0];

    // Command sequencer.
    always_comb begin
        n_state   = r_state;
        n_hw      = r_hw;
        n_live    = r_live;
        n_done    = 1'b0;
        n_status  = r_status;
        n_new_id  = r_new_id;
        n_valid   = r_valid;
        n_size    = r_size;
        n_usage   = r_usage;
        w_bit_set = 1'b0;
        w_bit_clr = 1'b0;
        w_bit_idx = r_slot;
        w_mem     = '0;
        w_mem.addr = r_slot;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_command == bidt_pkg::CMD_ALLOC) ? S_SCAN : S_READ;
                end
            end
            S_READ: begin
                n_live   = (r_id != '0) && (r_id <= r_hw) && r_alloc[r_slot];
                w_mem.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_done   = 1'b1;
                n_state  = S_IDLE;
                n_new_id = '0;
                n_status = bidt_pkg::ST_OK;
                n_valid  = 1'b1;
                n_size   = w_rd_size;
                n_usage  = w_rd_usage;
                case (r_cmd)
                    bidt_pkg::CMD_DELETE: begin
                        if (r_live) begin
                            w_mem.wr_size = 1'b1;
                            w_mem.size    = '0;
                            w_bit_clr     = 1'b1;
                            n_valid       = 1'b0;
                            n_size        = '0;
                            n_usage       = '0;
                        end
                    end
                    bidt_pkg::CMD_QUERY: begin
                    end
                    bidt_pkg::CMD_SETDATA: begin
                        if (r_live) begin
                            w_mem.wr_size  = 1'b1;
                            w_mem.wr_usage = 1'b1;
                            w_mem.size     = w_new_size;
                            w_mem.usage    = r_hint;
                            n_size         = w_new_size;
                            n_usage        = r_hint;
                        end
                    end
                    bidt_pkg::CMD_CHECK: begin
                        if (w_range_err) begin
                            n_status = bidt_pkg::ST_RANGE;
                        end
                    end
                    default: begin
                        n_live = 1'b0;
                    end
                endcase
                // A dead or out-of-range ID, or an unknown command, reports ST_BADID and no entry.
                if (!r_live || !(r_cmd inside {bidt_pkg::CMD_DELETE, bidt_pkg::CMD_QUERY,
                        bidt_pkg::CMD_SETDATA, bidt_pkg::CMD_CHECK})) begin
                    n_status = bidt_pkg::ST_BADID;
                    n_valid  = 1'b0;
                    n_size   = '0;
                    n_usage  = '0;
                end
            end
            S_SCAN: begin
                if (w_scan.done) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    n_size  = '0;
                    n_usage = '0;
                    if (w_scan.found) begin
                        w_bit_set      = 1'b1;
                        w_bit_idx      = w_scan.slot;
                        w_mem.addr     = w_scan.slot;
                        w_mem.wr_size  = 1'b1;
                        w_mem.wr_usage = 1'b1;
                        n_status       = bidt_pkg::ST_OK;
                        n_new_id       = {1'b0, w_scan.slot} + 1'b1;
                        n_valid        = 1'b1;
                        // The first never-used slot opens a new one above the mark.
                        if ({1'b0, w_scan.slot} == r_hw) begin
                            n_hw = r_hw + 1'b1;
                        end
                    end else begin
                        n_status = bidt_pkg::ST_FULL;
                        n_new_id = '0;
                        n_valid  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw    <= '0;
            r_done  <= 1'b0;
            r_live  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            r_done  <= n_done;
            r_live  <= n_live;
        end
    end

    // Allocation flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
        end else if (w_bit_set) begin
            r_alloc[w_bit_idx] <= 1'b1;
        end else if (w_bit_clr) begin
            r_alloc[w_bit_idx] <= 1'b0;
        end
    end

    // Command word capture and result word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_command;
            r_id   <= i_obj_id;
            r_slot <= w_id_m1[bidt_pkg::SLOT_W-1:0];
            r_len  <= i_length;
            r_off  <= i_start_offset;
            r_hint <= i_usage_hint;
        end
        r_status <= n_status;
        r_new_id <= n_new_id;
        r_valid  <= n_valid;
        r_size   <= n_size;
        r_usage  <= n_usage;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_new_id      = r_new_id;
    assign o_entry_valid = r_valid;
    assign o_entry_size  = r_size;
    assign o_entry_usage = r_usage;

    // A result only ever follows the act or search step.
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_EXEC) || ($past(r_state) == S_SCAN))
        else $error("result strobe without a finishing step");

    // The high-water mark never passes the table depth.
    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= bidt_pkg::ID_W'(bidt_pkg::MAX_IDS))
        else $error("high-water mark beyond table depth");

    // A handed-out ID is reported as a live entry.
    a_new_id_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_new_id != '0)) |-> (o_entry_valid && (o_status == bidt_pkg::ST_OK)))
        else $error("new ID reported without a live entry");

    // An accepted command word makes the block busy next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted word did not raise busy");

endmodule

// ----- hdl/bidt_scan.sv -----
module bidt_scan (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_go,
    input  logic [bidt_pkg::GROUP_W-1:0]       i_group,
    output logic [bidt_pkg::GRP_IDX_W-1:0]     o_grp,
    output bidt_pkg::t_scan_res                o_res
);

    logic                               r_active, n_active;
    logic [bidt_pkg::GRP_IDX_W-1:0]     r_grp, n_grp;
    bidt_pkg::t_scan_res                r_res, n_res;
    logic [bidt_pkg::GROUP_W-1:0]       w_free;
    logic                               w_has_free;
    logic [bidt_pkg::LANE_W-1:0]        w_low;

    // Lowest free lane within the group under inspection.
    always_comb begin
        w_free     = ~i_group;
        w_has_free = |w_free;
        w_low      = '0;
        for (int i = bidt_pkg::GROUP_W - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_low = bidt_pkg::LANE_W'(i);
            end
        end
    end

    // Walk the groups from the bottom until a free slot turns up or the last group is full.
    always_comb begin
        n_active  = r_active;
        n_grp     = r_grp;
        n_res     = r_res;
        n_res.done = 1'b0;
        if (i_go) begin
            n_active = 1'b1;
            n_grp    = '0;
        end else if (r_active) begin
            if (w_has_free) begin
                n_res.done  = 1'b1;
                n_res.found = 1'b1;
                n_res.slot  = {r_grp, w_low};
                n_active    = 1'b0;
            end else if (r_grp == bidt_pkg::GRP_IDX_W'(bidt_pkg::NUM_GROUPS - 1)) begin
                n_res.done  = 1'b1;
                n_res.found = 1'b0;
                n_active    = 1'b0;
            end else begin
                n_grp = r_grp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_grp    <= '0;
            r_res    <= '0;
        end else begin
            r_active <= n_active;
            r_grp    <= n_grp;
            r_res    <= n_res;
        end
    end

    assign o_grp = r_grp;
    assign o_res = r_res;

endmodule

// ----- hdl/bidt_store.sv -----
module bidt_store (
    input  logic                               i_clk,
    input  bidt_pkg::t_mem_req                 i_req,
    output logic [bidt_pkg::SIZE_W-1:0]        o_size,
    output logic [bidt_pkg::USAGE_W-1:0]       o_usage
);

    logic [bidt_pkg::SIZE_W-1:0]  r_size_mem  [bidt_pkg::MAX_IDS];
    logic [bidt_pkg::USAGE_W-1:0] r_usage_mem [bidt_pkg::MAX_IDS];
    logic [bidt_pkg::SIZE_W-1:0]  r_size_rd;
    logic [bidt_pkg::USAGE_W-1:0] r_usage_rd;

    // Single port: one address per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_size) begin
            r_size_mem[i_req.addr] <= i_req.size;
        end
        if (i_req.wr_usage) begin
            r_usage_mem[i_req.addr] <= i_req.usage;
        end
        if (i_req.rd) begin
            r_size_rd  <= r_size_mem[i_req.addr];
            r_usage_rd <= r_usage_mem[i_req.addr];
        end
    end

    assign o_size  = r_size_rd;
    assign o_usage = r_usage_rd;

endmodule
